/* hdl/fpim_pkg.sv */
// ----------------------------------------------------------------------------
// fpim_pkg: shared types and constants of the factor product index map
// Beat layouts, configuration register codes and the token that moves along
// the chain of division and mixing cells.
// ----------------------------------------------------------------------------
package fpim_pkg;

  localparam int IDX_W          = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int VCNT_W         = 4;
  localparam int MASK_W         = 8;
  localparam int DEF_MAX_VARS   = 8;
  localparam int DEF_DIGIT_BITS = 4;
  localparam int DIV_STEPS      = 8;
  localparam int DIV_CELLS      = IDX_W / DIV_STEPS;

  typedef enum logic [1:0] {
    CFG_VAR_COUNT    = 2'd0,
    CFG_DOMAIN_SIZES = 2'd1,
    CFG_FIRST_MASK   = 2'd2,
    CFG_SECOND_MASK  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] product_index;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
    logic             index_valid;
  } out_beat_t;

  typedef struct packed {
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] rest;
    logic [IDX_W-1:0] acc_a;
    logic [IDX_W-1:0] acc_b;
    logic [IDX_W-1:0] wt_a;
    logic [IDX_W-1:0] wt_b;
  } token_t;

endpackage

/* hdl/fpim_stream_if.sv */
// ----------------------------------------------------------------------------
// fpim_stream_if: valid/ready channel
// Carries one beat of the given payload type per accepted handshake.
// ----------------------------------------------------------------------------
interface fpim_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/factor_product_index_map.sv */
// ----------------------------------------------------------------------------
// factor_product_index_map: product entry index to operand entry indices
// Splits a product factor index into mixed-radix digits, last variable
// fastest, and re-encodes the digits of each operand, first variable most
// significant.
//
//   channel | dir | handshake         | payload
//   in_if   | in  | valid/ready       | product_index
//   out_if  | out | valid/ready       | first_index, second_index, index_valid
//   cfg_if  | in  | valid/ready       | index, data
//
// One beat per cycle is accepted while no stall reaches the input.
// Each variable takes four division cells of eight quotient bits and one mixing
// cell; the output register follows the last mixing cell.
// Reset clears the configuration registers and empties the chain at once.
// A stalled output backs the chain up cell by cell; bubbles are squeezed out.
// ----------------------------------------------------------------------------
module factor_product_index_map #(
  parameter int MAX_VARS   = fpim_pkg::DEF_MAX_VARS,
  parameter int DIGIT_BITS = fpim_pkg::DEF_DIGIT_BITS
) (
  input logic           clk,
  input logic           rst_n,
  fpim_stream_if.sink   in_if,
  fpim_stream_if.source out_if,
  fpim_stream_if.sink   cfg_if
);
  import fpim_pkg::*;

  localparam int NUM_LINKS = MAX_VARS * (DIV_CELLS + 1) + 1;
  localparam int LAST      = NUM_LINKS - 1;

  logic [VCNT_W-1:0]     var_count_r;
  logic [CFG_DATA_W-1:0] domain_sizes_r;
  logic [MASK_W-1:0]     first_mask_r;
  logic [MASK_W-1:0]     second_mask_r;

  token_t    tok_l [NUM_LINKS];
  logic      vld_l [NUM_LINKS];
  logic      rdy_l [NUM_LINKS];

  logic      out_valid_r;
  out_beat_t out_beat_r;
  out_beat_t out_nxt;
  logic      idx_ok;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r    <= '0;
      domain_sizes_r <= '0;
      first_mask_r   <= '0;
      second_mask_r  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.payload.index)
        CFG_VAR_COUNT:    var_count_r    <= cfg_if.payload.data[VCNT_W-1:0];
        CFG_DOMAIN_SIZES: domain_sizes_r <= cfg_if.payload.data;
        CFG_FIRST_MASK:   first_mask_r   <= cfg_if.payload.data[MASK_W-1:0];
        CFG_SECOND_MASK:  second_mask_r  <= cfg_if.payload.data[MASK_W-1:0];
      endcase
    end
  end

  assign vld_l[0]         = in_if.valid;
  assign in_if.ready      = rdy_l[0];
  assign tok_l[0].rest    = in_if.payload.product_index;
  assign tok_l[0].acc_a   = '0;
  assign tok_l[0].acc_b   = '0;
  assign tok_l[0].wt_a    = IDX_W'(1);
  assign tok_l[0].wt_b    = IDX_W'(1);

  for (genvar k = 0; k < MAX_VARS; k++) begin : g_var
    localparam int V     = MAX_VARS - 1 - k;
    localparam int SHIFT = k * DIGIT_BITS;
    localparam int BASE  = k * (DIV_CELLS + 1);

    logic [DIGIT_BITS-1:0] field;
    logic                  active;
    logic [DIGIT_BITS:0]   divisor;
    logic                  use_a;
    logic                  use_b;
    logic [DIGIT_BITS-1:0] rem_w [DIV_CELLS+1];

    if (SHIFT < CFG_DATA_W) begin : g_field
      assign field = DIGIT_BITS'(domain_sizes_r >> SHIFT);
    end else begin : g_nofield
      assign field = '0;
    end

    assign active  = (int'(var_count_r) > V);
    assign divisor = active ? ({1'b0, field} + (DIGIT_BITS+1)'(1)) : (DIGIT_BITS+1)'(1);

    if (V < MASK_W) begin : g_mask
      assign use_a = active && first_mask_r[V];
      assign use_b = active && second_mask_r[V];
    end else begin : g_nomask
      assign use_a = 1'b0;
      assign use_b = 1'b0;
    end

    assign rem_w[0] = '0;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
      fpim_div_cell #(
        .DIGIT_BITS (DIGIT_BITS)
      ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld_l[BASE+j]),
        .up_ready (rdy_l[BASE+j]),
        .up_tok   (tok_l[BASE+j]),
        .up_rem   (rem_w[j]),
        .divisor  (divisor),
        .dn_valid (vld_l[BASE+j+1]),
        .dn_ready (rdy_l[BASE+j+1]),
        .dn_tok   (tok_l[BASE+j+1]),
        .dn_rem   (rem_w[j+1])
      );
    end

    fpim_mix_cell #(
      .DIGIT_BITS (DIGIT_BITS)
    ) u_mix (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_l[BASE+DIV_CELLS]),
      .up_ready (rdy_l[BASE+DIV_CELLS]),
      .up_tok   (tok_l[BASE+DIV_CELLS]),
      .up_rem   (rem_w[DIV_CELLS]),
      .divisor  (divisor),
      .use_a    (use_a),
      .use_b    (use_b),
      .dn_valid (vld_l[BASE+DIV_CELLS+1]),
      .dn_ready (rdy_l[BASE+DIV_CELLS+1]),
      .dn_tok   (tok_l[BASE+DIV_CELLS+1])
    );
  end

  // Whatever quotient is left after the first variable is the overflow.
  assign idx_ok               = (tok_l[LAST].rest == '0);
  assign out_nxt.index_valid  = idx_ok;
  assign out_nxt.first_index  = idx_ok ? tok_l[LAST].acc_a : '0;
  assign out_nxt.second_index = idx_ok ? tok_l[LAST].acc_b : '0;

  assign rdy_l[LAST]    = !out_valid_r || out_if.ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_l[LAST]) begin
      out_valid_r <= vld_l[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_l[LAST] && vld_l[LAST]) begin
      out_beat_r <= out_nxt;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.payload.index_valid |->
      out_if.payload.first_index == '0 && out_if.payload.second_index == '0)
    else $error("invalid result beat carries nonzero indices");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result beat present right after reset");

  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> vld_l[1])
    else $error("accepted beat did not enter the first cell");

  a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
    vld_l[LAST] && !out_valid_r |=> out_valid_r)
    else $error("finished beat was not moved into the output register");

endmodule

/* hdl/fpim_div_cell.sv */
// ----------------------------------------------------------------------------
// fpim_div_cell: restoring division cell
// Runs a fixed number of long division steps on the running index against
// one domain size and hands the partial quotient and remainder onward.
// ----------------------------------------------------------------------------
module fpim_div_cell #(
  parameter int DIGIT_BITS = fpim_pkg::DEF_DIGIT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  fpim_pkg::token_t      up_tok,
  input  logic [DIGIT_BITS-1:0] up_rem,
  input  logic [DIGIT_BITS:0]   divisor,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output fpim_pkg::token_t      dn_tok,
  output logic [DIGIT_BITS-1:0] dn_rem
);
  import fpim_pkg::*;

  logic                  valid_r;
  token_t                tok_r;
  token_t                tok_nxt;
  logic [DIGIT_BITS-1:0] rem_r;
  logic [DIGIT_BITS-1:0] rem_nxt;
  logic [DIGIT_BITS:0]   trial;
  logic [DIGIT_BITS:0]   diff;
  logic                  fits;

  always_comb begin
    tok_nxt = up_tok;
    rem_nxt = up_rem;
    trial   = '0;
    diff    = '0;
    fits    = 1'b0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial        = {rem_nxt, tok_nxt.rest[IDX_W-1]};
      diff         = trial - divisor;
      fits         = (trial >= divisor);
      tok_nxt.rest = {tok_nxt.rest[IDX_W-2:0], fits};
      rem_nxt      = fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;
  assign dn_rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

/* hdl/fpim_mix_cell.sv */
// ----------------------------------------------------------------------------
// fpim_mix_cell: digit mixing cell
// Takes the finished digit of one variable and folds it into the operand
// indices whose masks claim the variable, scaling their place weights.
// ----------------------------------------------------------------------------
module fpim_mix_cell #(
  parameter int DIGIT_BITS = fpim_pkg::DEF_DIGIT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  fpim_pkg::token_t      up_tok,
  input  logic [DIGIT_BITS-1:0] up_rem,
  input  logic [DIGIT_BITS:0]   divisor,
  input  logic                  use_a,
  input  logic                  use_b,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output fpim_pkg::token_t      dn_tok
);
  import fpim_pkg::*;

  logic             valid_r;
  token_t           tok_r;
  token_t           tok_nxt;
  logic [IDX_W-1:0] digit;
  logic [IDX_W-1:0] size_w;

  assign digit  = IDX_W'(up_rem);
  assign size_w = IDX_W'(divisor);

  always_comb begin
    tok_nxt = up_tok;
    if (use_a) begin
      tok_nxt.acc_a = up_tok.acc_a + up_tok.wt_a * digit;
      tok_nxt.wt_a  = up_tok.wt_a * size_w;
    end
    if (use_b) begin
      tok_nxt.acc_b = up_tok.acc_b + up_tok.wt_b * digit;
      tok_nxt.wt_b  = up_tok.wt_b * size_w;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

/* verif/fpim_index_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpim_index_checker: scoreboard for the factor product index map
// Follows configuration writes and index beats, works out the operand
// indices of every accepted product index and compares each result beat
// against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module fpim_index_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fpim_pkg::in_beat_t  in_beat,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fpim_pkg::out_beat_t out_beat,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  fpim_pkg::cfg_beat_t cfg_beat,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);
  import fpim_pkg::*;

  localparam longint unsigned ENTRY_CAP = 64'h2_0000_0000;

  logic [VCNT_W-1:0] var_count;
  logic [IDX_W-1:0]  domain_sizes;
  logic [MASK_W-1:0] first_mask;
  logic [MASK_W-1:0] second_mask;

  out_beat_t expected_maps[$];

  function automatic longint unsigned radix_of(int pos);
    int               sh;
    longint unsigned  field;
    sh = (DEF_MAX_VARS - 1 - pos) * DEF_DIGIT_BITS;
    if (sh >= 32) begin
      return 1;
    end
    field = (domain_sizes >> sh) & ((32'd1 << DEF_DIGIT_BITS) - 1);
    return field + 1;
  endfunction

  function automatic out_beat_t map_index(logic [IDX_W-1:0] pidx);
    out_beat_t       res;
    longint unsigned entries;
    longint unsigned rest;
    longint unsigned digit[DEF_MAX_VARS];
    longint unsigned acc_a;
    longint unsigned acc_b;
    int              n;
    res = '0;
    n = (var_count > DEF_MAX_VARS) ? DEF_MAX_VARS : int'(var_count);
    entries = 1;
    for (int i = 0; i < n; i++) begin
      entries = entries * radix_of(i);
      if (entries > ENTRY_CAP) begin
        entries = ENTRY_CAP;
      end
    end
    if (longint'(pidx) >= entries) begin
      return res;
    end
    rest = pidx;
    for (int i = n - 1; i >= 0; i--) begin
      digit[i] = rest % radix_of(i);
      rest = rest / radix_of(i);
    end
    acc_a = 0;
    acc_b = 0;
    for (int i = 0; i < n; i++) begin
      if (first_mask[i]) begin
        acc_a = (acc_a * radix_of(i) + digit[i]) & 64'hFFFF_FFFF;
      end
      if (second_mask[i]) begin
        acc_b = (acc_b * radix_of(i) + digit[i]) & 64'hFFFF_FFFF;
      end
    end
    res.first_index  = acc_a[IDX_W-1:0];
    res.second_index = acc_b[IDX_W-1:0];
    res.index_valid  = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    int        bad;
    bad = 0;
    if (!rst_n) begin
      var_count    <= '0;
      domain_sizes <= '0;
      first_mask   <= '0;
      second_mask  <= '0;
      fail_count   <= 0;
      pending      <= 0;
      checked      <= 0;
      expected_maps.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_beat.index)
          CFG_VAR_COUNT: begin
            var_count <= cfg_beat.data[VCNT_W-1:0];
          end
          CFG_DOMAIN_SIZES: begin
            domain_sizes <= cfg_beat.data[IDX_W-1:0];
          end
          CFG_FIRST_MASK: begin
            first_mask <= cfg_beat.data[MASK_W-1:0];
          end
          CFG_SECOND_MASK: begin
            second_mask <= cfg_beat.data[MASK_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h %h %b", $time,
                   out_beat.first_index, out_beat.second_index, out_beat.index_valid);
          bad = 1;
        end else begin
          want = expected_maps.pop_front();
          if (out_beat.first_index !== want.first_index) begin
            $display("%0t: first_index expected %h got %h", $time,
                     want.first_index, out_beat.first_index);
            bad++;
          end
          if (out_beat.second_index !== want.second_index) begin
            $display("%0t: second_index expected %h got %h", $time,
                     want.second_index, out_beat.second_index);
            bad++;
          end
          if (out_beat.index_valid !== want.index_valid) begin
            $display("%0t: index_valid expected %b got %b", $time,
                     want.index_valid, out_beat.index_valid);
            bad++;
          end
        end
        checked <= checked + 1;
      end
      if (in_valid && in_ready) begin
        expected_maps = {expected_maps, map_index(in_beat.product_index)};
      end
      fail_count <= fail_count + bad;
      pending    <= expected_maps.size();
    end
  end

endmodule

/* verif/factor_product_index_map_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// factor_product_index_map_tb: top of the index map testbench
// Writes a series of variable lists, from empty and oversized lists to full
// tables, and streams product indices through the block with random gaps on
// both sides. A separate scoreboard predicts and compares every result beat.
// ----------------------------------------------------------------------------
module factor_product_index_map_tb;
  import fpim_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 60;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   cycles;
  int   items_sent;
  int   settings_used;
  int   fail_count;
  int   pending;
  int   checked;

  logic [IDX_W-1:0]  cur_sizes;
  longint unsigned   cur_entries;

  fpim_stream_if #(.payload_t(in_beat_t))  in_ch ();
  fpim_stream_if #(.payload_t(out_beat_t)) out_ch ();
  fpim_stream_if #(.payload_t(cfg_beat_t)) cfg_ch ();

  factor_product_index_map i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  fpim_index_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_beat    (in_ch.payload),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_beat   (out_ch.payload),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_beat   (cfg_ch.payload),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic offer_index(logic [IDX_W-1:0] value);
    if (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid                 <= 1'b1;
    in_ch.payload.product_index <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.payload.index <= idx;
    cfg_ch.payload.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_factor_setup(logic [VCNT_W-1:0] vcnt, logic [IDX_W-1:0] sizes,
                                   logic [MASK_W-1:0] fmask, logic [MASK_W-1:0] smask);
    int last;
    wait_for_results();
    write_reg(CFG_VAR_COUNT, CFG_DATA_W'(vcnt));
    write_reg(CFG_DOMAIN_SIZES, sizes);
    write_reg(CFG_FIRST_MASK, CFG_DATA_W'(fmask));
    write_reg(CFG_SECOND_MASK, CFG_DATA_W'(smask));
    cfg_ch.valid <= 1'b0;
    cur_sizes = sizes;
    last = (vcnt > DEF_MAX_VARS) ? DEF_MAX_VARS : int'(vcnt);
    cur_entries = 1;
    for (int i = 0; i < last; i++) begin
      cur_entries = cur_entries *
        (longint'(cur_sizes[(DEF_MAX_VARS-1-i)*DEF_DIGIT_BITS +: DEF_DIGIT_BITS]) + 1);
    end
    settings_used++;
  endtask

  initial begin
    int               r;
    logic [IDX_W-1:0] value;
    logic [VCNT_W-1:0] vcnt;
    logic [IDX_W-1:0] sizes;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    cur_entries = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty variable list straight out of reset.
    offer_index(32'h0000_0000);
    offer_index(32'h0000_0001);
    offer_index(32'hFFFF_FFFF);

    load_factor_setup(4'd8, 32'hFFFF_FFFF, 8'hFF, 8'h00);
    offer_index(32'h0000_0000);
    offer_index(32'hFFFF_FFFF);
    offer_index(32'h8000_0000);
    offer_index(32'h5A5A_5A5A);

    load_factor_setup(4'd15, 32'h1234_5670, 8'hAA, 8'h55);
    offer_index(32'd0);
    offer_index(32'd40319);
    offer_index(32'd40320);
    offer_index(32'd12345);

    load_factor_setup(4'd3, 32'h213F_FFFF, 8'hF9, 8'hF2);
    offer_index(32'd0);
    offer_index(32'd23);
    offer_index(32'd24);
    offer_index(32'd7);

    load_factor_setup(4'd0, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    offer_index(32'd0);
    offer_index(32'd1);

    load_factor_setup(4'd8, 32'h0000_0000, 8'hFF, 8'hFF);
    offer_index(32'd0);
    offer_index(32'd1);
    offer_index(32'd2);

    load_factor_setup(4'd4, 32'hF0F0_1234, 8'h0F, 8'h0F);
    offer_index(32'd0);
    offer_index(32'd255);
    offer_index(32'd256);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          vcnt  = 4'd8;
          sizes = 32'hFFFF_FFFF;
        end
        1: begin
          vcnt  = 4'($urandom_range(9, 15));
          sizes = $urandom;
        end
        2: begin
          vcnt  = 4'd8;
          sizes = $urandom & 32'h3333_3333;
        end
        default: begin
          vcnt  = 4'($urandom_range(1, 8));
          sizes = $urandom;
        end
      endcase
      load_factor_setup(vcnt, sizes, 8'($urandom), 8'($urandom));
      calm = (p == 4);
      for (int k = 0; k < 168; k++) begin
        if (p == 2 && k == 84) begin
          wait_for_results();
        end
        r = $urandom_range(99);
        if (cur_entries > 64'hFFFF_FFFF || r >= 85) begin
          value = $urandom;
        end else if (r < 70) begin
          value = $urandom_range(32'(cur_entries - 1));
        end else if (r < 80) begin
          value = 32'(cur_entries - 1);
        end else begin
          value = 32'(cur_entries);
        end
        offer_index(value);
      end
    end
    calm = 1'b0;

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Streamed %0d product indices over %0d variable list setups.",
             items_sent, settings_used);
    $display("Compared %0d result beats, in range and out of range.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
